// ----- hdl/pcfdm_pkg.sv -----
package pcfdm_pkg;

	// Timer and field widths
	localparam int TimerW = 16;
	localparam int OutW = 16;
	localparam int CfgW = 16;
	// Dividend holds ref_clock_hz or 100 * high time
	localparam int DivW = TimerW + 8;
	localparam int DivCntW = $clog2(DivW + 1);
	localparam int DutyScale = 100;
	localparam logic [CfgW-1:0] RefClkReset = CfgW'(32768);

	// Microprogram addressing
	localparam int PcW = 4;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_WAIT_IN,
		OP_PREP,
		OP_LOAD_F,
		OP_DIV,
		OP_LOAD_D,
		OP_EMIT,
		OP_STORE
	} op_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_ALWAYS,
		COND_NO_BEAT,
		COND_FILL_LT3,
		COND_PERIOD_ZERO,
		COND_DIV_MORE,
		COND_OUT_FULL
	} cond_t;

	typedef struct packed {
		op_t op;
		cond_t cond;
		logic [PcW-1:0] target;
	} uword_t;

	typedef struct packed {
		logic in_valid;
		logic fill_lt3;
		logic period_zero;
		logic div_more;
		logic out_full;
	} stat_t;

	// Program addresses
	localparam logic [PcW-1:0] PcWait = PcW'(0);
	localparam logic [PcW-1:0] PcDivF = PcW'(3);
	localparam logic [PcW-1:0] PcDivD = PcW'(5);
	localparam logic [PcW-1:0] PcEmit = PcW'(6);
	localparam logic [PcW-1:0] PcStore = PcW'(8);

	// Microprogram: one control word per step
	function automatic uword_t rom_word(input logic [PcW-1:0] addr);
		uword_t w;
		unique case (addr)
			PcW'(0): w = '{op: OP_WAIT_IN, cond: COND_NO_BEAT, target: PcWait};
			PcW'(1): w = '{op: OP_PREP, cond: COND_FILL_LT3, target: PcStore};
			PcW'(2): w = '{op: OP_LOAD_F, cond: COND_PERIOD_ZERO, target: PcEmit};
			PcW'(3): w = '{op: OP_DIV, cond: COND_DIV_MORE, target: PcDivF};
			PcW'(4): w = '{op: OP_LOAD_D, cond: COND_NEXT, target: PcWait};
			PcW'(5): w = '{op: OP_DIV, cond: COND_DIV_MORE, target: PcDivD};
			PcW'(6): w = '{op: OP_EMIT, cond: COND_OUT_FULL, target: PcEmit};
			PcW'(7): w = '{op: OP_NOP, cond: COND_ALWAYS, target: PcWait};
			PcW'(8): w = '{op: OP_STORE, cond: COND_ALWAYS, target: PcWait};
			default: w = '{op: OP_NOP, cond: COND_ALWAYS, target: PcWait};
		endcase
		return w;
	endfunction

	// Clamp a quotient to the output width
	function automatic logic [OutW-1:0] sat_out(input logic [DivW-1:0] v);
		logic [OutW-1:0] r;
		if (v[DivW-1:OutW] != '0) begin
			r = '1;
		end else begin
			r = v[OutW-1:0];
		end
		return r;
	endfunction

endpackage

// ----- hdl/pcfdm_if.sv -----
interface pcfdm_cap_if;
	logic valid;
	logic ready;
	logic [pcfdm_pkg::TimerW-1:0] capture_time;

	modport source (output valid, output capture_time, input ready);
	modport sink (input valid, input capture_time, output ready);
endinterface

interface pcfdm_res_if;
	logic valid;
	logic ready;
	logic [pcfdm_pkg::OutW-1:0] frequency_hz;
	logic [pcfdm_pkg::OutW-1:0] duty_percent;
	logic period_zero;

	modport source (output valid, output frequency_hz, output duty_percent,
		output period_zero, input ready);
	modport sink (input valid, input frequency_hz, input duty_percent,
		input period_zero, output ready);
endinterface

interface pcfdm_cfg_if;
	logic valid;
	logic ready;
	logic [pcfdm_pkg::CfgW-1:0] ref_clock_hz;

	modport source (output valid, output ref_clock_hz, input ready);
	modport sink (input valid, input ref_clock_hz, output ready);
endinterface

// ----- hdl/pcfdm_div.sv -----
module pcfdm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic                          step,
	input  logic [pcfdm_pkg::DivW-1:0]    dividend,
	input  logic [pcfdm_pkg::TimerW-1:0]  divisor,
	output logic [pcfdm_pkg::DivW-1:0]    quot,
	output logic                          more
);

	logic [pcfdm_pkg::DivCntW-1:0] cnt_q;
	logic [pcfdm_pkg::DivW-1:0]    quot_q;
	logic [pcfdm_pkg::TimerW-1:0]  rem_q;
	logic [pcfdm_pkg::TimerW-1:0]  dsr_q;
	logic [pcfdm_pkg::TimerW:0]    trial;
	logic                          fits;

	// One restoring step: shift in the next dividend bit, try a subtract
	assign trial = {rem_q, quot_q[pcfdm_pkg::DivW-1]};
	assign fits = trial >= {1'b0, dsr_q};

	// Count the remaining steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= pcfdm_pkg::DivCntW'(pcfdm_pkg::DivW);
		end else if (step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Advance quotient and remainder one bit per step
	always_ff @(posedge clk) begin
		if (load) begin
			quot_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (step && cnt_q != '0) begin
			if (fits) begin
				rem_q <= pcfdm_pkg::TimerW'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[pcfdm_pkg::TimerW-1:0];
			end
			quot_q <= {quot_q[pcfdm_pkg::DivW-2:0], fits};
		end
	end

	assign quot = quot_q;
	assign more = cnt_q != pcfdm_pkg::DivCntW'(1);

endmodule

// ----- hdl/pcfdm_seq.sv -----
module pcfdm_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  pcfdm_pkg::stat_t   stat,
	output pcfdm_pkg::op_t     op
);

	logic [pcfdm_pkg::PcW-1:0] pc_q;
	pcfdm_pkg::uword_t         uw;
	logic                      take;

	assign uw = pcfdm_pkg::rom_word(pc_q);
	assign op = uw.op;

	// Evaluate the jump condition of the current step
	always_comb begin
		unique case (uw.cond)
			pcfdm_pkg::COND_NEXT:        take = 1'b0;
			pcfdm_pkg::COND_ALWAYS:      take = 1'b1;
			pcfdm_pkg::COND_NO_BEAT:     take = !stat.in_valid;
			pcfdm_pkg::COND_FILL_LT3:    take = stat.fill_lt3;
			pcfdm_pkg::COND_PERIOD_ZERO: take = stat.period_zero;
			pcfdm_pkg::COND_DIV_MORE:    take = stat.div_more;
			pcfdm_pkg::COND_OUT_FULL:    take = stat.out_full;
			default:                     take = 1'b1;
		endcase
	end

	// Advance the step counter or jump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= pcfdm_pkg::PcWait;
		end else if (take) begin
			pc_q <= uw.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

// ----- hdl/pwm_capture_freq_duty_meter_unit.sv -----
// PWM frequency and duty meter. Each capture beat is a timer value latched on
// either edge of the PWM input. The first three captures after reset only fill
// the start, middle and end stamps; the fourth and every second one after it
// yields one result beat: frequency_hz = ref_clock_hz / period, duty_percent =
// floor(100 * high / period) clamped to 65535, period_zero set (and both values
// 0) when the period is zero. Periods and high times are taken modulo 2^16.
// A measuring capture runs two 24-step divisions that share one bit-serial
// restoring divider under a microcoded sequencer; a zero period skips both.
// The next capture is accepted while the result still waits in the output
// register. ref_clock_hz resets to 32768 and is written through the cfg
// channel, which is always ready.
module pwm_capture_freq_duty_meter_unit (
	input  logic          clk,
	input  logic          arst_n,
	pcfdm_cap_if.sink     capture,
	pcfdm_res_if.source   result,
	pcfdm_cfg_if.sink     cfg
);

	pcfdm_pkg::op_t                op;
	pcfdm_pkg::stat_t              stat;

	logic [pcfdm_pkg::CfgW-1:0]    ref_clk_q;
	logic [pcfdm_pkg::TimerW-1:0]  start_q;
	logic [pcfdm_pkg::TimerW-1:0]  mid_q;
	logic [pcfdm_pkg::TimerW-1:0]  end_q;
	logic [1:0]                    fill_q;
	logic [pcfdm_pkg::TimerW-1:0]  cap_q;
	logic [pcfdm_pkg::TimerW-1:0]  period_q;
	logic [pcfdm_pkg::TimerW-1:0]  high_q;
	logic [pcfdm_pkg::DivW-1:0]    high100_q;
	logic [pcfdm_pkg::OutW-1:0]    freq_q;
	logic                          out_valid_q;
	logic [pcfdm_pkg::OutW-1:0]    out_freq_q;
	logic [pcfdm_pkg::OutW-1:0]    out_duty_q;
	logic                          out_pz_q;

	logic                          div_load;
	logic [pcfdm_pkg::DivW-1:0]    div_dividend;
	logic [pcfdm_pkg::DivW-1:0]    div_quot;
	logic                          div_more;
	logic                          cap_beat;
	logic                          emit;
	logic                          pz;

	assign cap_beat = capture.valid && capture.ready;
	assign pz = period_q == '0;
	assign emit = (op == pcfdm_pkg::OP_EMIT) && !stat.out_full;

	assign stat.in_valid = capture.valid;
	assign stat.fill_lt3 = fill_q != 2'd3;
	assign stat.period_zero = pz;
	assign stat.div_more = div_more;
	assign stat.out_full = out_valid_q && !result.ready;

	pcfdm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.op     (op)
	);

	// Pick the dividend for the frequency or the duty division
	assign div_load = (op == pcfdm_pkg::OP_LOAD_F) || (op == pcfdm_pkg::OP_LOAD_D);
	assign div_dividend = (op == pcfdm_pkg::OP_LOAD_F)
		? pcfdm_pkg::DivW'(ref_clk_q) : high100_q;

	pcfdm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.step     (op == pcfdm_pkg::OP_DIV),
		.dividend (div_dividend),
		.divisor  (period_q),
		.quot     (div_quot),
		.more     (div_more)
	);

	assign capture.ready = op == pcfdm_pkg::OP_WAIT_IN;
	assign cfg.ready = 1'b1;

	// Hold the reference clock setting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_clk_q <= pcfdm_pkg::RefClkReset;
		end else if (cfg.valid && cfg.ready) begin
			ref_clk_q <= cfg.ref_clock_hz;
		end
	end

	// Stamps and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			mid_q <= '0;
			end_q <= '0;
			fill_q <= '0;
		end else if (op == pcfdm_pkg::OP_STORE) begin
			case (fill_q)
				2'd0:    start_q <= cap_q;
				2'd1:    mid_q <= cap_q;
				default: end_q <= cap_q;
			endcase
			fill_q <= fill_q + 2'd1;
		end else if (emit) begin
			start_q <= end_q;
			mid_q <= cap_q;
			fill_q <= 2'd2;
		end
	end

	// Datapath working registers
	always_ff @(posedge clk) begin
		if (cap_beat) begin
			cap_q <= capture.capture_time;
		end
		if (op == pcfdm_pkg::OP_PREP) begin
			period_q <= end_q - start_q;
			high_q <= mid_q - start_q;
		end
		if (op == pcfdm_pkg::OP_LOAD_F) begin
			high100_q <= pcfdm_pkg::DivW'(high_q) * pcfdm_pkg::DivW'(pcfdm_pkg::DutyScale);
		end
		if (op == pcfdm_pkg::OP_LOAD_D) begin
			freq_q <= pcfdm_pkg::sat_out(div_quot);
		end
	end

	// Output register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_pz_q <= pz;
			out_freq_q <= pz ? '0 : freq_q;
			out_duty_q <= pz ? '0 : pcfdm_pkg::sat_out(div_quot);
		end
	end

	assign result.valid = out_valid_q;
	assign result.frequency_hz = out_freq_q;
	assign result.duty_percent = out_duty_q;
	assign result.period_zero = out_pz_q;

endmodule

// ----- hdl/pcfdm_chk.sv -----
module pcfdm_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cap_valid,
	input logic                        cap_ready,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [pcfdm_pkg::OutW-1:0]  res_freq,
	input logic [pcfdm_pkg::OutW-1:0]  res_duty,
	input logic                        res_pz
);

	// A pending result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_freq) && $stable(res_duty)
			&& $stable(res_pz))
		else $error("result payload changed while stalled");

	// A capture beat leaves the sequencer busy in the following cycle
	a_cap_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cap_valid && cap_ready |=> !cap_ready)
		else $error("capture accepted on consecutive cycles");

	// Zero period forces zero values
	a_pz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_pz |-> res_freq == '0 && res_duty == '0)
		else $error("zero period with nonzero values");

endmodule

bind pwm_capture_freq_duty_meter_unit pcfdm_chk u_pcfdm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cap_valid (capture.valid),
	.cap_ready (capture.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_freq  (result.frequency_hz),
	.res_duty  (result.duty_percent),
	.res_pz    (result.period_zero)
);
